@@ design/sfcd_pkg.sv @@
// Shared types and constants for the sensor frame checksum decoder.
package sfcd_pkg;

  // Command codes on the item channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Frame format
  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam int unsigned LEN_OFFSET = 5;
  localparam int unsigned MIN_LEN    = 5;
  // Positions 0..16 cover the header and the longest payload (imu)
  localparam int unsigned NUM_HELD   = 17;

  // Function words
  localparam logic [7:0] FUNC_FLOW = 8'h51;
  localparam logic [7:0] FUNC_ALT  = 8'h52;
  localparam logic [7:0] FUNC_IMU  = 8'h53;
  localparam logic [7:0] FUNC_ATT  = 8'h54;

  // Subtype codes
  localparam logic [7:0] SUB_RAW   = 8'h00;
  localparam logic [7:0] SUB_FUSED = 8'h01;

  // Stale limit after reset
  localparam logic [15:0] STALE_LIMIT_RESET = 16'd10;

  typedef enum logic [2:0] {
    ST_DECODED       = 3'd0,
    ST_BAD_FRAME     = 3'd1,
    ST_BAD_CHECKSUM  = 3'd2,
    ST_TICK_COUNTING = 3'd3,
    ST_TICK_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    KIND_FLOW_RAW   = 4'd0,
    KIND_FLOW_FUSED = 4'd1,
    KIND_ALT_RAW    = 4'd2,
    KIND_ALT_FUSED  = 4'd3,
    KIND_IMU_RAW    = 4'd4,
    KIND_IMU_FILT   = 4'd5,
    KIND_EULER      = 4'd6,
    KIND_QUAT       = 4'd7,
    KIND_OTHER      = 4'd8
  } kind_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    status_t     status;
    kind_t       record_kind;
    logic [7:0]  quality;
    logic [7:0]  light;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [15:0] word_e;
    logic [15:0] word_f;
    logic        timeout_flag;
  } result_t;

endpackage

@@ design/sfcd_if.sv @@
// Channel interfaces: input items, results and the stale limit write port.
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output command, output rx_byte, output frame_end,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input frame_end,
                  output ready);
endinterface

interface sfcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  record_kind;
  logic [7:0]  quality;
  logic [7:0]  light;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic [15:0] word_e;
  logic [15:0] word_f;
  logic        timeout_flag;

  modport source (output valid, output status, output record_kind, output quality,
                  output light, output word_a, output word_b, output word_c,
                  output word_d, output word_e, output word_f, output timeout_flag,
                  input ready);
  modport sink   (input valid, input status, input record_kind, input quality,
                  input light, input word_a, input word_b, input word_c,
                  input word_d, input word_e, input word_f, input timeout_flag,
                  output ready);
endinterface

interface sfcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/sfcd_in_stage.sv @@
// Input register: holds one item until the decode stage consumes it.
module sfcd_in_stage
  import sfcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sfcd_in_if.sink   items,
  input  logic      go,
  output logic      s_valid,
  output item_t     s_item
);

  // Take a new item whenever the register is empty or being drained
  assign items.ready = !s_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (items.ready) begin
      s_valid <= items.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s_item.command   <= items.command;
      s_item.rx_byte   <= items.rx_byte;
      s_item.frame_end <= items.frame_end;
    end
  end

endmodule

@@ design/sfcd_core.sv @@
// Frame state, checks, decode and the result register.
module sfcd_core
  import sfcd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 32
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  input  item_t      s_item,
  output logic       go,
  sfcd_cfg_if.sink   cfg,
  sfcd_out_if.source results
);

  // Count runs to FRAME_BYTES + 1 to mark overflow
  localparam int unsigned CW = $clog2(FRAME_BYTES + 2);
  localparam logic [CW-1:0] FB = CW'(FRAME_BYTES);

  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]    sum, sum_next;
  logic [15:0]   stale_count, stale_next;
  logic          timed_out, to_next;
  logic [15:0]   stale_limit;
  logic [7:0]    store [NUM_HELD];

  logic          emit;
  logic          adv;
  logic          o_valid;
  result_t       res, res_next;
  logic [7:0]    e [NUM_HELD];
  logic [9:0]    len_cmp, hdr_len;
  logic          bad_frame;
  kind_t         kind;

  // Frame bytes as seen after this byte: stored, current, or zero past the end
  always_comb begin
    for (int p = 0; p < NUM_HELD; p++) begin
      if (cnt == CW'(p)) begin
        e[p] = s_item.rx_byte;
      end else if (cnt > CW'(p)) begin
        e[p] = store[p];
      end else begin
        e[p] = 8'h00;
      end
    end
  end

  // Header and length check
  assign len_cmp = 10'(cnt) + 10'd1;
  assign hdr_len = 10'(e[3]) + 10'(LEN_OFFSET);
  assign bad_frame = (cnt >= FB) || (len_cmp < 10'(MIN_LEN)) ||
                     (e[0] != SYNC_BYTE) || (e[1] != SYNC_BYTE) ||
                     (hdr_len != len_cmp);

  // Record kind from function word and subtype
  always_comb begin
    case (e[2])
      FUNC_FLOW: kind = (e[4] == SUB_RAW) ? KIND_FLOW_RAW : KIND_FLOW_FUSED;
      FUNC_ALT:  kind = (e[4] == SUB_RAW) ? KIND_ALT_RAW  : KIND_ALT_FUSED;
      FUNC_IMU:  kind = (e[4] == SUB_RAW) ? KIND_IMU_RAW  : KIND_IMU_FILT;
      FUNC_ATT:  kind = (e[4] == SUB_RAW) ? KIND_EULER    : KIND_QUAT;
      default:   kind = KIND_OTHER;
    endcase
    if (e[4] != SUB_RAW && e[4] != SUB_FUSED) begin
      kind = KIND_OTHER;
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    res_next    = '0;
    cnt_next    = cnt;
    sum_next    = sum;
    stale_next  = stale_count;
    to_next     = timed_out;
    emit        = 1'b0;
    if (s_valid) begin
      if (s_item.command == CMD_TICK) begin
        emit = 1'b1;
        if (stale_count < stale_limit) begin
          stale_next = stale_count + 16'd1;
        end else begin
          to_next = 1'b1;
        end
        res_next.status = to_next ? ST_TICK_TIMEOUT : ST_TICK_COUNTING;
      end else begin
        if (cnt <= FB) begin
          cnt_next = cnt + CW'(1);
        end
        sum_next = sum + s_item.rx_byte;
        if (s_item.frame_end) begin
          emit     = 1'b1;
          cnt_next = '0;
          sum_next = '0;
          if (bad_frame) begin
            res_next.status = ST_BAD_FRAME;
          end else begin
            stale_next = '0;
            // The last byte carries the sum of all bytes before it
            if (sum != s_item.rx_byte) begin
              res_next.status = ST_BAD_CHECKSUM;
            end else begin
              res_next.status      = ST_DECODED;
              res_next.record_kind = kind;
              case (kind)
                KIND_FLOW_RAW: begin
                  res_next.quality = e[5];
                  res_next.word_a  = {8'h00, e[6]};
                  res_next.word_b  = {8'h00, e[7]};
                  res_next.light   = e[8];
                end
                KIND_FLOW_FUSED: begin
                  res_next.quality = e[5];
                  res_next.word_a  = {e[6], e[7]};
                  res_next.word_b  = {e[8], e[9]};
                  res_next.word_c  = {e[10], e[11]};
                  res_next.word_d  = {e[12], e[13]};
                  res_next.light   = e[14];
                end
                KIND_ALT_RAW, KIND_ALT_FUSED: begin
                  res_next.word_a = {e[5], e[6]};
                end
                KIND_IMU_RAW, KIND_IMU_FILT: begin
                  res_next.word_a = {e[5], e[6]};
                  res_next.word_b = {e[7], e[8]};
                  res_next.word_c = {e[9], e[10]};
                  res_next.word_d = {e[11], e[12]};
                  res_next.word_e = {e[13], e[14]};
                  res_next.word_f = {e[15], e[16]};
                end
                KIND_EULER: begin
                  res_next.word_a = {e[5], e[6]};
                  res_next.word_b = {e[7], e[8]};
                  res_next.word_c = {e[9], e[10]};
                end
                KIND_QUAT: begin
                  res_next.word_a = {e[5], e[6]};
                  res_next.word_b = {e[7], e[8]};
                  res_next.word_c = {e[9], e[10]};
                  res_next.word_d = {e[11], e[12]};
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      res_next.timeout_flag = to_next;
    end
  end

  // Stage drains unless it has a result and the output register is held
  assign go  = !emit || !o_valid || results.ready;
  assign adv = s_valid && go;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      sum         <= '0;
      stale_count <= '0;
      timed_out   <= 1'b0;
    end else if (adv) begin
      cnt         <= cnt_next;
      sum         <= sum_next;
      stale_count <= stale_next;
      timed_out   <= to_next;
    end
  end

  // Frame byte store, written at the current position
  always_ff @(posedge clk) begin
    if (adv && s_item.command == CMD_BYTE) begin
      for (int p = 0; p < NUM_HELD; p++) begin
        if (cnt == CW'(p)) begin
          store[p] <= s_item.rx_byte;
        end
      end
    end
  end

  // Stale limit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
    end else if (cfg.valid) begin
      stale_limit <= cfg.data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv && emit) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res <= res_next;
    end
  end

  assign results.valid        = o_valid;
  assign results.status       = res.status;
  assign results.record_kind  = res.record_kind;
  assign results.quality      = res.quality;
  assign results.light        = res.light;
  assign results.word_a       = res.word_a;
  assign results.word_b       = res.word_b;
  assign results.word_c       = res.word_c;
  assign results.word_d       = res.word_d;
  assign results.word_e       = res.word_e;
  assign results.word_f       = res.word_f;
  assign results.timeout_flag = res.timeout_flag;

endmodule

@@ design/sensor_frame_checksum_decoder_top.sv @@
// Top level of the sensor frame checksum decoder.
//
// Takes one transaction per clock on the item channel unless the result
// register is held full: a received UART byte (with its end-of-frame mark)
// or a poll tick. Each item passes the input register and is checked and
// decoded in one pass into the result register; the sustained rate is one
// item per cycle while results drain. The frame counters and stale counter
// update in that same pass. A byte closing a frame and every tick give one
// result; other bytes give none. The result register lets items that give
// no result pass while a result waits. The user must write the stale limit
// (reset 10) on the cfg channel only while idle; the block does not enforce it.
// FRAME_BYTES (18..256) sets the largest frame before overflow is reported.
module sensor_frame_checksum_decoder_top
  import sfcd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 32
)
(
  input  logic       clk,
  input  logic       rst,
  sfcd_in_if.sink    items,
  sfcd_out_if.source results,
  sfcd_cfg_if.sink   cfg
);

  logic  s_valid;
  item_t s_item;
  logic  go;

  sfcd_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .go      (go),
    .s_valid (s_valid),
    .s_item  (s_item)
  );

  sfcd_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_valid),
    .s_item  (s_item),
    .go      (go),
    .cfg     (cfg),
    .results (results)
  );

endmodule

@@ design/sfcd_checker.sv @@
// Port-level assertions for the decoder, bound to the top level.
module sfcd_checker
  import sfcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [3:0]  record_kind,
  input logic [7:0]  quality,
  input logic [15:0] word_a,
  input logic        timeout_flag
);

  logic seen_timeout;

  // Remember a delivered timeout
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_timeout <= 1'b0;
    end else if (out_valid && out_ready && timeout_flag) begin
      seen_timeout <= 1'b1;
    end
  end

  // A pending result is not withdrawn
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Timeout stays set once reported
  assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_timeout |-> timeout_flag)
    else $error("timeout flag cleared");

  // Tick status agrees with the timeout flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TICK_TIMEOUT || status == ST_TICK_COUNTING)
      |-> (timeout_flag == (status == ST_TICK_TIMEOUT)))
    else $error("tick status disagrees with timeout flag");

  // Only decoded frames carry payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DECODED
      |-> record_kind == 4'd0 && quality == 8'd0 && word_a == 16'd0)
    else $error("payload on a non-decoded result");

endmodule

bind sensor_frame_checksum_decoder_top sfcd_checker u_sfcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .status       (results.status),
  .record_kind  (results.record_kind),
  .quality      (results.quality),
  .word_a       (results.word_a),
  .timeout_flag (results.timeout_flag)
);
